[sv/dnra_pkg.sv]
// Shared types, constants and helpers of the device number range allocator.
`timescale 1ns / 1ps

package dnra_pkg;

   // Number space geometry
   localparam int MAJOR_SLOTS = 256;
   localparam int MINOR_COUNT = 256;
   localparam int WORD_BITS   = 64;
   localparam int MAP_WORDS   = MINOR_COUNT / WORD_BITS;
   localparam int GROUP_WIDTH = 8;
   localparam int GROUPS      = MAJOR_SLOTS / GROUP_WIDTH;
   localparam int MAJOR_W     = $clog2(MAJOR_SLOTS);
   localparam int WORD_IDX_W  = $clog2(MAP_WORDS);
   localparam int GROUP_IDX_W = $clog2(GROUPS);
   localparam int GROUP_SEL_W = $clog2(GROUP_WIDTH);
   localparam int MEM_DEPTH   = MAJOR_SLOTS * MAP_WORDS;

   // Request modes
   localparam logic [1:0] MODE_REGISTER   = 2'd0;
   localparam logic [1:0] MODE_ALLOC      = 2'd1;
   localparam logic [1:0] MODE_UNREGISTER = 2'd2;

   // Response status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_RANGE   = 2'd1;
   localparam logic [1:0] ST_USED    = 2'd2;
   localparam logic [1:0] ST_NOMAJOR = 2'd3;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] major;
      logic [7:0] first_minor;
      logic [8:0] count;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] result_major;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic       load;
      logic       grp_inc;
      logic       take_found;
      logic       mem_read;
      logic       word_write;
      logic       word_next;
      logic       word_reset;
      logic       fresh_set;
      logic       fresh_clr;
      logic       commit_claim;
      logic       commit_release;
      logic       finish;
      logic [1:0] fin_status;
      logic       fin_use_major;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [1:0] mode;
      logic       range_bad;
      logic       hit;
      logic       last_group;
      logic       flag;
      logic       overlap;
      logic       last_word;
   } stat_type;

   // Bits of one bitmap word that fall inside [lo, hi)
   function automatic logic [WORD_BITS-1:0] word_mask(logic [WORD_IDX_W-1:0] w,
                                                      logic [8:0] lo, logic [9:0] hi);
      logic [WORD_BITS-1:0] m;
      logic [9:0]           pos;
      m = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         pos  = 10'({w, 6'(j)});
         m[j] = (pos >= {1'b0, lo}) && (pos < hi);
      end
      return m;
   endfunction

endpackage

[sv/dnra_ctrl.sv]
// Controller state machine of the device number range allocator.
`timescale 1ns / 1ps

module dnra_ctrl
   import dnra_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     busy
);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_DECIDE = 9'b000000010,
      S_SEARCH = 9'b000000100,
      S_LOOKUP = 9'b000001000,
      S_CHK_RD = 9'b000010000,
      S_CHK_EV = 9'b000100000,
      S_WR_RD  = 9'b001000000,
      S_WR_EV  = 9'b010000000,
      S_COMMIT = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   assign busy = (state_ff != S_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (stat.mode != MODE_REGISTER && stat.mode != MODE_ALLOC &&
                stat.mode != MODE_UNREGISTER) begin
               cmd.finish     = 1'b1;
               cmd.fin_status = ST_NOMAJOR;
               state_in       = S_IDLE;
            end else if (stat.range_bad) begin
               cmd.finish     = 1'b1;
               cmd.fin_status = ST_RANGE;
               state_in       = S_IDLE;
            end else if (stat.mode == MODE_ALLOC) begin
               state_in = S_SEARCH;
            end else begin
               state_in = S_LOOKUP;
            end
         end
         S_SEARCH: begin
            if (stat.hit) begin
               cmd.take_found = 1'b1;
               state_in       = S_LOOKUP;
            end else if (stat.last_group) begin
               cmd.finish     = 1'b1;
               cmd.fin_status = ST_NOMAJOR;
               state_in       = S_IDLE;
            end else begin
               cmd.grp_inc = 1'b1;
            end
         end
         S_LOOKUP: begin
            if (stat.mode == MODE_UNREGISTER) begin
               if (!stat.flag) begin
                  cmd.finish     = 1'b1;
                  cmd.fin_status = ST_NOMAJOR;
                  state_in       = S_IDLE;
               end else begin
                  cmd.fresh_clr = 1'b1;
                  state_in      = S_WR_RD;
               end
            end else if (stat.flag) begin
               cmd.fresh_clr = 1'b1;
               state_in      = S_CHK_RD;
            end else begin
               cmd.fresh_set = 1'b1;
               state_in      = S_WR_RD;
            end
         end
         S_CHK_RD: begin
            cmd.mem_read = 1'b1;
            state_in     = S_CHK_EV;
         end
         S_CHK_EV: begin
            if (stat.overlap) begin
               cmd.finish     = 1'b1;
               cmd.fin_status = ST_USED;
               state_in       = S_IDLE;
            end else if (stat.last_word) begin
               cmd.word_reset = 1'b1;
               state_in       = S_WR_RD;
            end else begin
               cmd.word_next = 1'b1;
               state_in      = S_CHK_RD;
            end
         end
         S_WR_RD: begin
            cmd.mem_read = 1'b1;
            state_in     = S_WR_EV;
         end
         S_WR_EV: begin
            cmd.word_write = 1'b1;
            if (stat.last_word) begin
               state_in = S_COMMIT;
            end else begin
               cmd.word_next = 1'b1;
               state_in      = S_WR_RD;
            end
         end
         S_COMMIT: begin
            cmd.finish     = 1'b1;
            cmd.fin_status = ST_OK;
            if (stat.mode == MODE_UNREGISTER) begin
               cmd.commit_release = 1'b1;
            end else begin
               cmd.commit_claim  = 1'b1;
               cmd.fin_use_major = 1'b1;
            end
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[sv/dnra_dp.sv]
// Datapath of the device number range allocator: flags, bitmap memory, response.
`timescale 1ns / 1ps

module dnra_dp
   import dnra_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  cmd_type  cmd,
   output stat_type stat,
   output logic     rsp_strobe,
   output rsp_type  rsp_data
);

   // Request and walk registers
   req_type                 req_ff;
   logic [MAJOR_W-1:0]      cur_major_ff;
   logic [GROUP_IDX_W-1:0]  grp_ff;
   logic [WORD_IDX_W-1:0]   word_ff;
   logic                    fresh_ff;
   logic                    nonzero_ff;
   logic [MAJOR_SLOTS-1:0]  major_flag_ff;
   logic [WORD_BITS-1:0]    rdata_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff;

   logic [WORD_BITS-1:0]    bitmap_mem [MEM_DEPTH];

   logic [9:0]              range_end;
   logic [WORD_BITS-1:0]    mask;
   logic [WORD_BITS-1:0]    new_word;
   logic [GROUP_WIDTH-1:0]  free_bits;
   logic [GROUP_SEL_W-1:0]  free_sel;
   logic [MAJOR_W-1:0]      found_major;
   logic [$clog2(MEM_DEPTH)-1:0] addr;

   assign range_end = 10'(req_ff.first_minor) + 10'(req_ff.count);
   assign mask      = word_mask(word_ff, 9'(req_ff.first_minor), range_end);
   assign addr      = {cur_major_ff, word_ff};

   // New bitmap word: claim sets the range, unregister clears it
   always_comb begin
      if (req_ff.mode == MODE_UNREGISTER) begin
         new_word = rdata_ff & ~mask;
      end else if (fresh_ff) begin
         new_word = mask;
      end else begin
         new_word = rdata_ff | mask;
      end
   end

   // Lowest free major in the current group, major zero excluded
   always_comb begin
      free_bits = ~major_flag_ff[grp_ff*GROUP_WIDTH +: GROUP_WIDTH];
      if (grp_ff == '0) begin
         free_bits[0] = 1'b0;
      end
      free_sel = '0;
      for (int i = GROUP_WIDTH - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            free_sel = GROUP_SEL_W'(i);
         end
      end
   end
   assign found_major = {grp_ff, free_sel};

   always_comb begin
      stat.mode       = req_ff.mode;
      stat.range_bad  = (range_end > 10'(MINOR_COUNT));
      stat.hit        = |free_bits;
      stat.last_group = (grp_ff == GROUP_IDX_W'(GROUPS - 1));
      stat.flag       = major_flag_ff[cur_major_ff];
      stat.overlap    = |(rdata_ff & mask);
      stat.last_word  = (word_ff == WORD_IDX_W'(MAP_WORDS - 1));
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         major_flag_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
         if (cmd.commit_claim) begin
            major_flag_ff[cur_major_ff] <= 1'b1;
         end else if (cmd.commit_release && !nonzero_ff) begin
            major_flag_ff[cur_major_ff] <= 1'b0;
         end
      end
   end

   // Payload and walk registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff       <= req_data;
         cur_major_ff <= req_data.major;
         grp_ff       <= '0;
         word_ff      <= '0;
         nonzero_ff   <= 1'b0;
      end else begin
         if (cmd.grp_inc) begin
            grp_ff <= grp_ff + 1'b1;
         end
         if (cmd.take_found) begin
            cur_major_ff <= found_major;
         end
         if (cmd.word_reset) begin
            word_ff <= '0;
         end else if (cmd.word_next) begin
            word_ff <= word_ff + 1'b1;
         end
         if (cmd.word_write) begin
            nonzero_ff <= nonzero_ff | (|new_word);
         end
      end
      if (cmd.fresh_set) begin
         fresh_ff <= 1'b1;
      end else if (cmd.fresh_clr) begin
         fresh_ff <= 1'b0;
      end
      if (cmd.finish) begin
         rsp_ff.status       <= cmd.fin_status;
         rsp_ff.result_major <= cmd.fin_use_major ? cur_major_ff : '0;
      end
   end

   // Bitmap memory, one word per access
   always_ff @(posedge clock) begin
      if (cmd.word_write) begin
         bitmap_mem[addr] <= new_word;
      end
      if (cmd.mem_read) begin
         rdata_ff <= bitmap_mem[addr];
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule

[sv/device_number_range_allocator.sv]
// Top level of the device number range allocator.
// Usage:
//   A request is taken when start is high and busy is low; req_data carries
//   mode, major, first_minor and count. Mode register claims a minor range on
//   a given major, allocate claims it on the lowest free major from 1 upward,
//   unregister clears the range and frees the major once its bitmap is empty.
//   Exactly one response per request appears on rsp_data for one cycle,
//   marked by rsp_strobe; the receiver cannot stall it.
// Sequence:
//   A range error or unused mode is answered from the decide state without
//   touching the bitmap. Otherwise the bitmap is walked one 64-bit word at a
//   time, a read state then an evaluate state per word, over a single-port
//   memory (check pass for a major already in use, then update pass, four
//   words each), and allocate first scans the major flags eight per cycle;
//   one request at a time, busy stays high until the response is issued, and
//   a new request may be taken in the cycle the response shows.
// Reset:
//   Synchronous reset clears every major flag and the controller. Bitmap
//   words of a free major are never used before they are written.
`timescale 1ns / 1ps

module device_number_range_allocator
   import dnra_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   dnra_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   dnra_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // An accepted request keeps the block busy
   assert property (@(posedge clock) disable iff (reset) start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   // A response only follows a request in progress
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |-> $past(busy))
      else $error("response without request");

   // Failed requests report major zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status != ST_OK |-> rsp_data.result_major == '0)
      else $error("nonzero major on failed request");

endmodule

[tb/dnra_checker.sv]
// Response checker of the device number range allocator: predicts and compares.
`timescale 1ns / 1ps

module dnra_checker
   import dnra_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_strobe,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending
);

   // Shadow number space
   logic                   major_used [MAJOR_SLOTS];
   logic [MINOR_COUNT-1:0] minor_map  [MAJOR_SLOTS];
   rsp_type                expected_rsps [$];

   assign pending = expected_rsps.size();

   task automatic report_mismatch(input string what, input logic [9:0] got,
                                  input logic [9:0] want);
      $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   // Claim a range on major m; returns the status code
   function automatic logic [1:0] claim_range(int m, int first, int cnt);
      logic [MINOR_COUNT-1:0] mask;
      mask = '0;
      for (int i = 0; i < cnt; i++) mask[first + i] = 1'b1;
      if (major_used[m]) begin
         if ((minor_map[m] & mask) != '0) return ST_USED;
      end else begin
         major_used[m] = 1'b1;
         minor_map[m]  = '0;
      end
      minor_map[m] |= mask;
      return ST_OK;
   endfunction

   function automatic rsp_type predict_response(req_type r);
      rsp_type                p;
      int                     first, cnt, found;
      logic                   span_ok;
      logic [MINOR_COUNT-1:0] mask;
      p = '{status: ST_NOMAJOR, result_major: 8'd0};
      first = int'(r.first_minor);
      cnt = int'(r.count);
      span_ok = (first < MINOR_COUNT) && (first + cnt <= MINOR_COUNT);
      case (r.mode)
         MODE_REGISTER: begin
            if (!span_ok) p.status = ST_RANGE;
            else begin
               p.status = claim_range(int'(r.major), first, cnt);
               if (p.status == ST_OK) p.result_major = r.major;
            end
         end
         MODE_ALLOC: begin
            if (!span_ok) p.status = ST_RANGE;
            else begin
               found = 0;
               for (int i = 1; i < MAJOR_SLOTS; i++)
                  if (found == 0 && !major_used[i]) found = i;
               if (found != 0) begin
                  p.status = claim_range(found, first, cnt);
                  if (p.status == ST_OK) p.result_major = 8'(found);
               end
            end
         end
         MODE_UNREGISTER: begin
            if (!span_ok) p.status = ST_RANGE;
            else if (major_used[r.major]) begin
               mask = '0;
               for (int i = 0; i < cnt; i++) mask[first + i] = 1'b1;
               minor_map[r.major] &= ~mask;
               if (minor_map[r.major] == '0) major_used[r.major] = 1'b0;
               p.status = ST_OK;
            end
         end
         default: ;
      endcase
      return p;
   endfunction

   // Watch both channels
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         fail_count = 0;
         expected_rsps.delete();
         for (int i = 0; i < MAJOR_SLOTS; i++) begin
            major_used[i] = 1'b0;
            minor_map[i]  = '0;
         end
      end else begin
         if (rsp_strobe) begin
            if (expected_rsps.size() == 0)
               report_mismatch("unexpected response, status", 10'(rsp_data.status),
                               10'd0);
            else begin
               want = expected_rsps.pop_front();
               if (rsp_data.status != want.status)
                  report_mismatch("status", 10'(rsp_data.status), 10'(want.status));
               if (rsp_data.result_major != want.result_major)
                  report_mismatch("result_major", 10'(rsp_data.result_major),
                                  10'(want.result_major));
            end
         end
         if (start && !busy) expected_rsps.push_back(predict_response(req_data));
      end
   end

endmodule

[tb/device_number_range_allocator_tb.sv]
// Testbench top of the device number range allocator: stimulus and verdict.
`timescale 1ns / 1ps

module device_number_range_allocator_tb;
   import dnra_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;
   int      cycle_count = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   device_number_range_allocator u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   dnra_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending(pending)
   );

   // Run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Issue one request, hold it until taken, then idle a random gap
   task automatic send_request(input logic [1:0] mode, input logic [7:0] major,
                               input logic [7:0] first, input logic [8:0] cnt);
      int gap;
      req_data <= '{mode: mode, major: major, first_minor: first, count: cnt};
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Random span, mostly legal, sometimes off the end of the map
   task automatic pick_span(output logic [7:0] first, output logic [8:0] cnt);
      int sel;
      sel = $urandom_range(0, 9);
      first = 8'($urandom_range(0, 255));
      if (sel == 0) cnt = 9'($urandom_range(0, 511));
      else if (sel < 3) cnt = 9'(256 - first);
      else cnt = 9'($urandom_range(0, (256 - first) < 16 ? 256 - first : 16));
   endtask

   initial begin
      logic [7:0] maj, first;
      logic [8:0] cnt;
      int         sel;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, every mode, zero count, major zero, bad ranges
      send_request(MODE_REGISTER,   8'd0,   8'd0,   9'd256);
      send_request(MODE_REGISTER,   8'd0,   8'd5,   9'd1);
      send_request(MODE_REGISTER,   8'd255, 8'd255, 9'd1);
      send_request(MODE_REGISTER,   8'd255, 8'd0,   9'd255);
      send_request(MODE_REGISTER,   8'd7,   8'd255, 9'd2);
      send_request(MODE_REGISTER,   8'd9,   8'd10,  9'd0);
      send_request(MODE_ALLOC,      8'd200, 8'd0,   9'd256);
      send_request(MODE_ALLOC,      8'd0,   8'd100, 9'd0);
      send_request(MODE_ALLOC,      8'd0,   8'd1,   9'd511);
      send_request(MODE_UNREGISTER, 8'd0,   8'd0,   9'd256);
      send_request(MODE_UNREGISTER, 8'd0,   8'd0,   9'd1);
      send_request(MODE_UNREGISTER, 8'd9,   8'd0,   9'd0);
      send_request(MODE_UNREGISTER, 8'd42,  8'd0,   9'd4);
      send_request(MODE_UNREGISTER, 8'd255, 8'd0,   9'd256);
      send_request(MODE_UNREGISTER, 8'd255, 8'd200, 9'd100);
      send_request(2'd3,            8'hAA,  8'h55,  9'h155);
      send_request(2'd3,            8'h55,  8'hAA,  9'h0AA);

      // Random: clustered majors to get overlaps, frees and reuse
      for (int n = 0; n < 120; n++) begin
         sel = $urandom_range(0, 19);
         pick_span(first, cnt);
         maj = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, 12));
         if (sel < 7) send_request(MODE_REGISTER, maj, first, cnt);
         else if (sel < 13)
            send_request(MODE_ALLOC, 8'($urandom_range(0, 255)), first, cnt);
         else if (sel < 19) begin
            if ($urandom_range(0, 2) != 0) begin
               first = 8'd0;
               cnt = 9'd256;
            end
            send_request(MODE_UNREGISTER, maj, first, cnt);
         end else
            send_request(2'd3, maj, first, cnt);
      end
      // Exhaust the free majors, then release part of them
      for (int i = 0; i < 260; i++) send_request(MODE_ALLOC, 8'd0, 8'd3, 9'd1);
      for (int i = 0; i < 150; i++)
         send_request(MODE_UNREGISTER, 8'(i), 8'd0, 9'd256);
      start <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[filelist.f]
sv/dnra_pkg.sv
sv/dnra_ctrl.sv
sv/dnra_dp.sv
sv/device_number_range_allocator.sv
tb/dnra_checker.sv
tb/device_number_range_allocator_tb.sv
